// File: hdl/chmc_pkg.sv
// shared constants, types and helpers for the monotone chain hull block
`timescale 1ns / 1ps
package chmc_pkg;
	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;
	localparam int IDX_BITS = $clog2(MAX_POINTS);
	localparam int CNT_BITS = $clog2(MAX_POINTS + 1);
	localparam int STACK_DEPTH = 2 * MAX_POINTS;
	localparam int TOP_BITS = $clog2(STACK_DEPTH + 1);
	localparam int SP_BITS = $clog2(STACK_DEPTH);
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// word handed from the front part to the back part
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   fin;
	} pt_word_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_WR,
		ST_HULL_NEXT,
		ST_HULL_RD,
		ST_HULL_MUL,
		ST_HULL_CMP,
		ST_HULL_DEC,
		ST_EMIT_RD,
		ST_EMIT_WAIT,
		ST_EMIT_OUT
	} bk_state_t;

	// strict lexicographic order: a before b
	function automatic logic lex_before(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		lex_before = (ax != bx) ? (ax < bx) : (ay < by);
	endfunction
endpackage

// File: hdl/chmc_ram.sv
// generic single write port ram with registered reads
`timescale 1ns / 1ps
module chmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end
endmodule

// File: hdl/chmc_front.sv
// input side: takes point words and passes them through a short queue
`timescale 1ns / 1ps
module chmc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  chmc_pkg::coord_t    point_x,
	input  chmc_pkg::coord_t    point_y,
	input  logic                final_point,
	output logic                q_valid,
	output chmc_pkg::pt_word_t  q_word,
	input  logic                q_pop
);
	import chmc_pkg::*;

	pt_word_t               buf_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wp_q, rp_q;
	logic [QPTR_BITS:0]     cnt_q;
	logic                   push;

	assign stall = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign push = valid && !stall;
	assign q_valid = (cnt_q != '0);
	assign q_word = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= '{x: point_x, y: point_y, fin: final_point};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(q_pop);
		end
	end
endmodule

// File: hdl/chmc_back.sv
// hull engine: stores points, insertion sort, chain passes and vertex output
`timescale 1ns / 1ps
module chmc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  chmc_pkg::pt_word_t q_word,
	output logic               q_pop,
	output logic               valid,
	input  logic               stall,
	output chmc_pkg::coord_t   vertex_x,
	output chmc_pkg::coord_t   vertex_y,
	output logic               last_vertex,
	output logic               points_dropped
);
	import chmc_pkg::*;

	bk_state_t state_q, state_d;

	logic [CNT_BITS-1:0] count_q;
	logic                ovf_q;
	logic [CNT_BITS-1:0] si_q;   // sort outer index
	logic [IDX_BITS-1:0] sj_q;   // sort inner index
	logic [CNT_BITS-1:0] hi_q;   // hull point index
	logic                upper_q;
	logic [TOP_BITS-1:0] top_q, base_q;
	logic [TOP_BITS-1:0] len_q, ek_q;
	coord_t              hx_q, hy_q;
	logic signed [PROD_BITS-1:0] p1_q, p2_q;

	// point ram controls
	logic                pwe_x, pwe_y;
	logic [IDX_BITS-1:0] pwa;
	coord_t              pwd_x, pwd_y;
	logic [IDX_BITS-1:0] pra, prb;
	coord_t              pxa, pxb, pya, pyb;

	// stack ram controls
	logic                swe;
	logic [SP_BITS-1:0]  swa, sra, srb;
	logic [IDX_BITS-1:0] swd, sda, sdb;

	// output register
	logic   ov_q;
	coord_t ox_q, oy_q;
	logic   ol_q, od_q;

	chmc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk, .we(pwe_x), .waddr(pwa), .wdata(pwd_x),
		.raddr_a(pra), .rdata_a(pxa), .raddr_b(prb), .rdata_b(pxb));
	chmc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk, .we(pwe_y), .waddr(pwa), .wdata(pwd_y),
		.raddr_a(pra), .rdata_a(pya), .raddr_b(prb), .rdata_b(pyb));
	chmc_ram #(.WIDTH(IDX_BITS), .DEPTH(STACK_DEPTH)) u_ram_stk (
		.clk, .we(swe), .waddr(swa), .wdata(swd),
		.raddr_a(sra), .rdata_a(sda), .raddr_b(srb), .rdata_b(sdb));

	// hull turn test operands: stack-addressed points come via a second read
	logic                hstage_q;
	logic signed [DIFF_BITS-1:0] ax, ay, bx, by;
	coord_t ox_r_q, oy_r_q, ax_r_q, ay_r_q;

	assign ax = DIFF_BITS'(ax_r_q) - DIFF_BITS'(ox_r_q);
	assign ay = DIFF_BITS'(ay_r_q) - DIFF_BITS'(oy_r_q);
	assign bx = DIFF_BITS'(hx_q) - DIFF_BITS'(ox_r_q);
	assign by = DIFF_BITS'(hy_q) - DIFF_BITS'(oy_r_q);

	logic [CNT_BITS-1:0] n_pts;
	logic                is_fin_in;
	logic [TOP_BITS-1:0] min_top;
	assign n_pts = count_q;
	assign min_top = upper_q ? base_q : TOP_BITS'(2);

	assign valid = ov_q;
	assign vertex_x = ox_q;
	assign vertex_y = oy_q;
	assign last_vertex = ol_q;
	assign points_dropped = od_q;

	logic [CNT_BITS-1:0] cnt_d;
	logic ovf_d;
	logic [CNT_BITS-1:0] si_d;
	logic [IDX_BITS-1:0] sj_d;
	logic [CNT_BITS-1:0] hi_d;
	logic upper_d;
	logic [TOP_BITS-1:0] top_d, base_d, len_d, ek_d;
	logic load_out;
	logic hstage_d;
	logic cap_ops, cap_h;

	always_comb begin
		state_d = state_q;
		cnt_d = count_q;
		ovf_d = ovf_q;
		si_d = si_q;
		sj_d = sj_q;
		hi_d = hi_q;
		upper_d = upper_q;
		top_d = top_q;
		base_d = base_q;
		len_d = len_q;
		ek_d = ek_q;
		hstage_d = hstage_q;
		q_pop = 1'b0;
		pwe_x = 1'b0;
		pwe_y = 1'b0;
		pwa = '0;
		pwd_x = q_word.x;
		pwd_y = q_word.y;
		pra = sj_q;
		prb = sj_q - 1'b1;
		swe = 1'b0;
		swa = top_q[SP_BITS-1:0];
		swd = hi_q[IDX_BITS-1:0];
		sra = SP_BITS'(top_q - TOP_BITS'(2));
		srb = SP_BITS'(top_q - TOP_BITS'(1));
		load_out = 1'b0;
		cap_ops = 1'b0;
		cap_h = 1'b0;
		is_fin_in = q_word.fin;
		unique case (state_q)
			ST_LOAD: begin
				if (q_valid) begin
					q_pop = 1'b1;
					pwa = count_q[IDX_BITS-1:0];
					if (count_q < CNT_BITS'(MAX_POINTS)) begin
						pwe_x = 1'b1;
						pwe_y = 1'b1;
						cnt_d = count_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					if (is_fin_in) begin
						si_d = CNT_BITS'(1);
						sj_d = IDX_BITS'(1);
						state_d = ST_SORT_RD;
					end
				end
			end
			ST_SORT_RD: begin
				if (si_q >= n_pts || n_pts < CNT_BITS'(2)) begin
					hi_d = '0;
					top_d = '0;
					upper_d = 1'b0;
					if (n_pts == CNT_BITS'(1)) begin
						len_d = TOP_BITS'(1);
						ek_d = '0;
						state_d = ST_EMIT_RD;
					end else if (n_pts == '0) begin
						cnt_d = '0;
						ovf_d = 1'b0;
						state_d = ST_LOAD;
					end else begin
						state_d = ST_HULL_NEXT;
					end
				end else begin
					state_d = ST_SORT_CMP;
				end
			end
			ST_SORT_CMP: begin
				if (lex_before(pxa, pya, pxb, pyb)) begin
					pwe_x = 1'b1;
					pwe_y = 1'b1;
					pwa = sj_q;
					pwd_x = pxb;
					pwd_y = pyb;
					state_d = ST_SORT_WR;
				end else begin
					si_d = si_q + 1'b1;
					sj_d = si_d[IDX_BITS-1:0];
					state_d = ST_SORT_RD;
				end
			end
			ST_SORT_WR: begin
				pwe_x = 1'b1;
				pwe_y = 1'b1;
				pwa = sj_q - 1'b1;
				pwd_x = hx_q;
				pwd_y = hy_q;
				if (sj_q == IDX_BITS'(1)) begin
					si_d = si_q + 1'b1;
					sj_d = si_d[IDX_BITS-1:0];
				end else begin
					sj_d = sj_q - 1'b1;
				end
				state_d = ST_SORT_RD;
			end
			ST_HULL_NEXT: begin
				// read the candidate point and the two stack tops
				pra = hi_q[IDX_BITS-1:0];
				hstage_d = 1'b0;
				if (top_q >= min_top) begin
					state_d = ST_HULL_RD;
				end else begin
					swe = 1'b1;
					top_d = top_q + 1'b1;
					state_d = ST_HULL_DEC;
				end
			end
			ST_HULL_RD: begin
				if (!hstage_q) begin
					cap_h = 1'b1;
					pra = sda;
					prb = sdb;
					hstage_d = 1'b1;
				end else begin
					cap_ops = 1'b1;
					state_d = ST_HULL_MUL;
				end
			end
			ST_HULL_MUL: begin
				// products register this cycle
				state_d = ST_HULL_CMP;
			end
			ST_HULL_CMP: begin
				if (p1_q - p2_q <= 0) begin
					top_d = top_q - 1'b1;
					state_d = ST_HULL_NEXT;
				end else begin
					swe = 1'b1;
					top_d = top_q + 1'b1;
					state_d = ST_HULL_DEC;
				end
			end
			ST_HULL_DEC: begin
				// step to the next point of the chain
				if (!upper_q) begin
					if (hi_q + 1'b1 == n_pts) begin
						upper_d = 1'b1;
						base_d = top_q + 1'b1;
						hi_d = n_pts - CNT_BITS'(2);
						state_d = ST_HULL_NEXT;
					end else begin
						hi_d = hi_q + 1'b1;
						state_d = ST_HULL_NEXT;
					end
				end else if (hi_q == '0) begin
					len_d = top_q - 1'b1;
					ek_d = '0;
					state_d = ST_EMIT_RD;
				end else begin
					hi_d = hi_q - 1'b1;
					state_d = ST_HULL_NEXT;
				end
			end
			ST_EMIT_RD: begin
				sra = SP_BITS'(len_q - ek_q - 1'b1);
				state_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				sra = SP_BITS'(len_q - ek_q - 1'b1);
				pra = (n_pts == CNT_BITS'(1)) ? '0 : sda;
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				// keep both reads pointed at the vertex while the output waits
				sra = SP_BITS'(len_q - ek_q - 1'b1);
				pra = (n_pts == CNT_BITS'(1)) ? '0 : sda;
				if (!ov_q || !stall) begin
					load_out = 1'b1;
					if (ek_q + 1'b1 == len_q) begin
						cnt_d = '0;
						ovf_d = 1'b0;
						state_d = ST_LOAD;
					end else begin
						ek_d = ek_q + 1'b1;
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SORT_CMP) begin
			hx_q <= pxa;
			hy_q <= pya;
		end
		if (cap_h) begin
			hx_q <= pxa;
			hy_q <= pya;
		end
		if (cap_ops) begin
			ox_r_q <= pxa;
			oy_r_q <= pya;
			ax_r_q <= pxb;
			ay_r_q <= pyb;
		end
		p1_q <= PROD_BITS'(ax) * PROD_BITS'(by);
		p2_q <= PROD_BITS'(ay) * PROD_BITS'(bx);
		if (load_out) begin
			ox_q <= pxa;
			oy_q <= pya;
			ol_q <= (ek_q + 1'b1 == len_q);
			od_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			si_q <= '0;
			sj_q <= '0;
			hi_q <= '0;
			upper_q <= 1'b0;
			top_q <= '0;
			base_q <= '0;
			len_q <= '0;
			ek_q <= '0;
			hstage_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= cnt_d;
			ovf_q <= ovf_d;
			si_q <= si_d;
			sj_q <= sj_d;
			hi_q <= hi_d;
			upper_q <= upper_d;
			top_q <= top_d;
			base_q <= base_d;
			len_q <= len_d;
			ek_q <= ek_d;
			hstage_q <= hstage_d;
			if (load_out) ov_q <= 1'b1;
			else if (!stall) ov_q <= 1'b0;
		end
	end
endmodule

// File: hdl/convex_hull_monotone_chain.sv
// top level of the monotone chain convex hull block
`timescale 1ns / 1ps
// usage
// input channel: valid/stall, one point word per accepted cycle
// (point_x, point_y, final_point); final_point closes the set
// a two-word queue decouples the input from the hull engine, so words
// keep flowing while the engine is loading
// up to MAX_POINTS points are kept, later ones are dropped and
// points_dropped is set on every vertex of that set
// after the final word the engine sorts by insertion (read, compare and,
// on a swap, a second write; up to n*n/2 compares), then runs the lower
// and upper chains, each turn test reading the stack tops and points, then
// multiplying and comparing, then emits the vertices clockwise, each read
// from the stack then the point ram; load is one word per cycle
// output channel: valid/stall, one vertex word per accept, last_vertex
// marks the end of the set; a stalled word holds until taken and the
// engine waits on it
// reset (arst_n low) empties the queue and the point set and drops any
// pending output word
module convex_hull_monotone_chain (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  chmc_pkg::coord_t point_x,
	input  chmc_pkg::coord_t point_y,
	input  logic             final_point,
	output logic             out_valid,
	input  logic             out_stall,
	output chmc_pkg::coord_t vertex_x,
	output chmc_pkg::coord_t vertex_y,
	output logic             last_vertex,
	output logic             points_dropped
);
	import chmc_pkg::*;

	logic     q_valid, q_pop;
	pt_word_t q_word;

	// front: accept and buffer point words
	chmc_front u_front (
		.clk, .arst_n,
		.valid(in_valid), .stall(in_stall),
		.point_x, .point_y, .final_point,
		.q_valid, .q_word, .q_pop);

	// back: store, sort, chain passes, vertex output
	chmc_back u_back (
		.clk, .arst_n,
		.q_valid, .q_word, .q_pop,
		.valid(out_valid), .stall(out_stall),
		.vertex_x, .vertex_y, .last_vertex, .points_dropped);
endmodule

// File: tb/tb.sv
// self-checking testbench for the monotone chain convex hull block
`timescale 1ns / 1ps
module tb;
	import chmc_pkg::*;

	// one expected vertex word
	typedef struct {
		coord_t x;
		coord_t y;
		logic   last;
		logic   dropped;
	} vertex_t;

	// point set mirror and expected vertex queue
	class hull_scoreboard;
		int      set_x[MAX_POINTS];
		int      set_y[MAX_POINTS];
		int      set_count;
		bit      set_overflow;
		vertex_t hull_words[$];
		int      errors;

		function new();
			set_count = 0;
			set_overflow = 0;
			errors = 0;
		endfunction

		function automatic longint turn_val(int o, int a, int b);
			longint ax, ay, bx, by;
			ax = longint'(set_x[a]) - set_x[o];
			ay = longint'(set_y[a]) - set_y[o];
			bx = longint'(set_x[b]) - set_x[o];
			by = longint'(set_y[b]) - set_y[o];
			return ax * by - ay * bx;
		endfunction

		function automatic void push_vertex(int idx, bit last);
			vertex_t v;
			v.x = coord_t'(set_x[idx]);
			v.y = coord_t'(set_y[idx]);
			v.last = last;
			v.dropped = set_overflow;
			hull_words.insert(hull_words.size(), v);
		endfunction

		// accepted input word: store it and, on the final one, build the hull
		function automatic void note_point(coord_t x, coord_t y, logic fin);
			int chain[2*MAX_POINTS];
			int depth, n, lower_base, len, tx, ty, j;
			if (set_count < MAX_POINTS) begin
				set_x[set_count] = int'(x);
				set_y[set_count] = int'(y);
				set_count++;
			end else begin
				set_overflow = 1;
			end
			if (!fin)
				return;
			n = set_count;
			if (n == 1) begin
				push_vertex(0, 1);
			end else begin
				// insertion sort by x, then y
				for (int i = 1; i < n; i++) begin
					j = i;
					while (j > 0 && ((set_x[j] != set_x[j-1]) ? (set_x[j] < set_x[j-1])
							: (set_y[j] < set_y[j-1]))) begin
						tx = set_x[j]; ty = set_y[j];
						set_x[j] = set_x[j-1]; set_y[j] = set_y[j-1];
						set_x[j-1] = tx; set_y[j-1] = ty;
						j--;
					end
				end
				depth = 0;
				for (int i = 0; i < n; i++) begin
					while (depth >= 2 && turn_val(chain[depth-2], chain[depth-1], i) <= 0)
						depth--;
					if (depth < 2*MAX_POINTS) begin
						chain[depth] = i;
						depth++;
					end
				end
				lower_base = depth + 1;
				for (int i = n - 2; i >= 0; i--) begin
					while (depth >= lower_base
							&& turn_val(chain[depth-2], chain[depth-1], i) <= 0)
						depth--;
					if (depth < 2*MAX_POINTS) begin
						chain[depth] = i;
						depth++;
					end
				end
				len = depth - 1;
				if (len > MAX_POINTS)
					len = MAX_POINTS;
				// stack is counterclockwise, walk it backward for clockwise
				for (int k = 0; k < len; k++)
					push_vertex(chain[len-1-k] % MAX_POINTS, k == len - 1);
			end
			set_count = 0;
			set_overflow = 0;
		endfunction

		function automatic void check_vertex(coord_t x, coord_t y, logic last, logic dropped);
			vertex_t v;
			if (hull_words.size() == 0) begin
				$error("unexpected vertex word x=%0d y=%0d", x, y);
				errors++;
				return;
			end
			v = hull_words.pop_front();
			if (x !== v.x) begin
				$error("vertex_x expected %0d actual %0d", v.x, x);
				errors++;
			end
			if (y !== v.y) begin
				$error("vertex_y expected %0d actual %0d", v.y, y);
				errors++;
			end
			if (last !== v.last) begin
				$error("last_vertex expected %0b actual %0b", v.last, last);
				errors++;
			end
			if (dropped !== v.dropped) begin
				$error("points_dropped expected %0b actual %0b", v.dropped, dropped);
				errors++;
			end
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	coord_t point_x;
	coord_t point_y;
	logic   final_point;
	logic   out_valid;
	logic   out_stall;
	coord_t vertex_x;
	coord_t vertex_y;
	logic   last_vertex;
	logic   points_dropped;

	hull_scoreboard sb = new();
	int  words_sent = 0;
	bit  quiet = 0;        // no idling in the last part of the run
	int  stuck_cycles = 0;

	localparam int STUCK_LIMIT = 200000;
	localparam int RANDOM_WORDS = 260;

	convex_hull_monotone_chain uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.point_x(point_x),
		.point_y(point_y),
		.final_point(final_point),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.last_vertex(last_vertex),
		.points_dropped(points_dropped)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// send one point word, with an optional idle burst ahead of it
	task automatic send_point(coord_t x, coord_t y, logic fin);
		bit taken;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1;
		point_x <= x;
		point_y <= y;
		final_point <= fin;
		taken = 0;
		while (!taken) begin
			// handshake inputs settle well before the falling edge
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		sb.note_point(x, y, fin);
		words_sent++;
	endtask

	// random coordinate: full range or a tight cluster that makes
	// collinear runs and duplicates likely
	function automatic coord_t pick_coord(bit tight);
		if (tight)
			return coord_t'($urandom_range(0, 8)) - coord_t'(4);
		return coord_t'($urandom);
	endfunction

	task automatic send_random_set(int count);
		bit tight;
		tight = ($urandom_range(0, 2) == 0);
		for (int i = 0; i < count; i++)
			send_point(pick_coord(tight), pick_coord(tight), i == count - 1);
	endtask

	// drop the input and wait for every expected vertex
	task automatic wait_drained();
		in_valid <= 0;
		while (sb.hull_words.size() != 0)
			@(posedge clk);
	endtask

	// output side: random stall bursts
	initial begin
		out_stall <= 0;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				out_stall <= 0;
				@(posedge clk);
			end else begin
				out_stall <= 1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	// collect vertex words; sampled at the falling edge so no race with the block
	initial begin
		bit     take;
		coord_t vx, vy;
		logic   vl, vd;
		forever begin
			@(negedge clk);
			take = arst_n && out_valid && !out_stall;
			vx = vertex_x; vy = vertex_y; vl = last_vertex; vd = points_dropped;
			@(posedge clk);
			if (take)
				sb.check_vertex(vx, vy, vl, vd);
		end
	end

	// watchdog on cycles without any accepted word
	initial begin
		forever begin
			@(negedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 0;
		in_valid <= 0;
		point_x <= '0;
		point_y <= '0;
		final_point <= 0;
		repeat (11) @(posedge clk);
		arst_n = 1;
		@(posedge clk);

		// single point at the coordinate extremes
		send_point(coord_t'(32767), coord_t'(-32768), 1);
		// two points
		send_point(coord_t'(-32768), coord_t'(32767), 0);
		send_point(coord_t'(32767), coord_t'(-32768), 1);
		// copies of one point
		send_point(coord_t'(5), coord_t'(5), 0);
		send_point(coord_t'(5), coord_t'(5), 0);
		send_point(coord_t'(5), coord_t'(5), 1);
		// collinear run, out of order
		send_point(coord_t'(2), coord_t'(2), 0);
		send_point(coord_t'(0), coord_t'(0), 0);
		send_point(coord_t'(3), coord_t'(3), 0);
		send_point(coord_t'(1), coord_t'(1), 1);
		// full-range square with an interior point and an edge point
		send_point(coord_t'(0), coord_t'(0), 0);
		send_point(coord_t'(-32768), coord_t'(-32768), 0);
		send_point(coord_t'(32767), coord_t'(32767), 0);
		send_point(coord_t'(32767), coord_t'(-32768), 0);
		send_point(coord_t'(0), coord_t'(32767), 0);
		send_point(coord_t'(-32768), coord_t'(32767), 1);
		// all-ones and zero bit patterns
		send_point(coord_t'(-1), coord_t'(0), 0);
		send_point(coord_t'(0), coord_t'(-1), 0);
		send_point(coord_t'(-1), coord_t'(-1), 1);

		// sender holds off until every vertex is out
		wait_drained();

		// store overflow, final point dropped too
		send_random_set(MAX_POINTS + 2);

		while (words_sent < RANDOM_WORDS) begin
			if (words_sent > 220)
				quiet = 1;
			case ($urandom_range(0, 19))
				0: send_random_set(1);
				1: send_random_set(MAX_POINTS + $urandom_range(1, 4));
				default: send_random_set($urandom_range(2, 10));
			endcase
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.hull_words.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule
